// ----- hw/rtl/ssfb_pkg.sv -----
package ssfb_pkg;

  localparam logic [1:0] MODE_DIGITS  = 2'd0;
  localparam logic [1:0] MODE_POINTS  = 2'd1;
  localparam logic [1:0] MODE_LEDS    = 2'd2;
  localparam logic [1:0] MODE_REFRESH = 2'd3;

  localparam logic [7:0] BLANK_CODE   = 8'hFF;
  localparam logic [7:0] POINT_MASK   = 8'h08;
  localparam logic [7:0] LED_LIMIT    = 8'h1F;
  localparam logic [7:0] SEL_LIMIT    = 8'h03;
  localparam logic [7:0] SYS_RESET    = 8'h01;

  localparam logic [7:0] CMD_SYSTEM   = 8'h48;
  localparam logic [7:0] CMD_RIGHT    = 8'h6A;
  localparam logic [7:0] CMD_LEDS     = 8'h6C;
  localparam logic [7:0] CMD_LEFT     = 8'h6E;

  localparam int unsigned BEATS     = 8;
  localparam int unsigned IDX_W     = $clog2(BEATS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BEATS - 1);

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] left_digit_code;
    logic [7:0] right_digit_code;
    logic [7:0] point_select;
    logic [7:0] key_led_bits;
  } ssfb_req_t;

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       start_before;
    logic       stop_after;
    logic       last;
  } ssfb_rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } ssfb_state_t;

  typedef struct packed {
    logic             apply_update;
    logic             load_beat;
    logic [IDX_W-1:0] beat_idx;
  } ssfb_cmd_t;

  typedef struct packed {
    logic rsp_blocked;
  } ssfb_status_t;

  function automatic logic [7:0] seg_lookup(input logic [3:0] code);
    logic [7:0] seg;
    case (code)
      4'h0: seg = 8'hE7;
      4'h1: seg = 8'h81;
      4'h2: seg = 8'h75;
      4'h3: seg = 8'hB5;
      4'h4: seg = 8'h93;
      4'h5: seg = 8'hB6;
      4'h6: seg = 8'hF6;
      4'h7: seg = 8'h85;
      4'h8: seg = 8'hF7;
      4'h9: seg = 8'hB7;
      4'hA: seg = 8'h66;
      4'hB: seg = 8'hF1;
      4'hC: seg = 8'h56;
      4'hD: seg = 8'hD3;
      4'hE: seg = 8'h62;
      4'hF: seg = 8'hC7;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

  function automatic logic [7:0] led_map(input logic [4:0] keys);
    return {keys[2], keys[3], keys[4], 2'b00, keys[0], keys[1], 1'b0};
  endfunction

  function automatic logic code_bad(input logic [7:0] code);
    return (code != BLANK_CODE) && (code > 8'd15);
  endfunction

endpackage

// ----- hw/rtl/ssfb_ctrl.sv -----
module ssfb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic [1:0]           req_mode,
  output logic                 req_stall,
  input  ssfb_pkg::ssfb_status_t status,
  output ssfb_pkg::ssfb_cmd_t  cmd
);
  import ssfb_pkg::*;

  ssfb_state_t      state;
  ssfb_state_t      state_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic             accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    req_stall        = 1'b1;
    accept           = 1'b0;
    cmd.apply_update = 1'b0;
    cmd.load_beat    = 1'b0;
    cmd.beat_idx     = idx;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        accept    = req_valid;
        if (accept) begin
          if (req_mode == MODE_REFRESH) begin
            state_next = ST_EMIT;
            idx_next   = '0;
          end else begin
            cmd.apply_update = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (!status.rsp_blocked) begin
          cmd.load_beat = 1'b1;
          idx_next      = idx + 1'b1;
          if (idx == LAST_IDX) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/ssfb_datapath.sv -----
module ssfb_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  ssfb_pkg::ssfb_req_t   req,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_data,
  input  ssfb_pkg::ssfb_cmd_t   cmd,
  output ssfb_pkg::ssfb_status_t status,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output ssfb_pkg::ssfb_rsp_t   rsp
);
  import ssfb_pkg::*;

  logic [7:0] sys_setting;
  logic [7:0] right_byte;
  logic [7:0] led_byte;
  logic [7:0] left_byte;
  logic [7:0] right_byte_next;
  logic [7:0] led_byte_next;
  logic [7:0] left_byte_next;
  logic [7:0] beat_byte;

  assign status.rsp_blocked = rsp_valid && rsp_stall;

  always_comb begin
    right_byte_next = right_byte;
    led_byte_next   = led_byte;
    left_byte_next  = left_byte;
    if (cmd.apply_update) begin
      case (req.mode)
        MODE_DIGITS: begin
          if (code_bad(req.left_digit_code) || code_bad(req.right_digit_code)) begin
            right_byte_next = '0;
            left_byte_next  = '0;
          end else begin
            right_byte_next = (req.right_digit_code == BLANK_CODE) ?
                              (right_byte & POINT_MASK) :
                              seg_lookup(req.right_digit_code[3:0]);
            left_byte_next  = (req.left_digit_code == BLANK_CODE) ?
                              (left_byte & POINT_MASK) :
                              seg_lookup(req.left_digit_code[3:0]);
          end
        end
        MODE_POINTS: begin
          if (req.point_select > SEL_LIMIT) begin
            right_byte_next = '0;
            led_byte_next   = '0;
            left_byte_next  = '0;
          end else begin
            left_byte_next  = req.point_select[0] ? (left_byte | POINT_MASK) :
                                                    (left_byte & ~POINT_MASK);
            right_byte_next = req.point_select[1] ? (right_byte | POINT_MASK) :
                                                    (right_byte & ~POINT_MASK);
          end
        end
        MODE_LEDS: begin
          if (req.key_led_bits > LED_LIMIT) begin
            right_byte_next = '0;
            led_byte_next   = '0;
            left_byte_next  = '0;
          end else begin
            led_byte_next = led_map(req.key_led_bits[4:0]);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sys_setting <= SYS_RESET;
      right_byte  <= '0;
      led_byte    <= '0;
      left_byte   <= '0;
    end else begin
      if (cfg_we) begin
        sys_setting <= cfg_data;
      end
      right_byte <= right_byte_next;
      led_byte   <= led_byte_next;
      left_byte  <= left_byte_next;
    end
  end

  // Even beats carry a command byte, odd beats the data byte of that command.
  always_comb begin
    case (cmd.beat_idx[IDX_W-1:1])
      2'd0:    beat_byte = cmd.beat_idx[0] ? sys_setting : CMD_SYSTEM;
      2'd1:    beat_byte = cmd.beat_idx[0] ? right_byte  : CMD_RIGHT;
      2'd2:    beat_byte = cmd.beat_idx[0] ? led_byte    : CMD_LEDS;
      2'd3:    beat_byte = cmd.beat_idx[0] ? left_byte   : CMD_LEFT;
      default: beat_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_beat) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_beat) begin
      rsp.bus_byte     <= beat_byte;
      rsp.start_before <= !cmd.beat_idx[0];
      rsp.stop_after   <= cmd.beat_idx[0];
      rsp.last         <= (cmd.beat_idx == LAST_IDX);
    end
  end

endmodule

// ----- hw/rtl/seven_segment_frame_buffer_ctrl_unit.sv -----
// Display buffer controller for a two-digit seven-segment driver chip with key LEDs. Digit,
// decimal point and key LED items update the frame bytes and give no beats. A refresh item
// makes the block emit eight bus beats, one per cycle from the output register when the bus
// side does not stall, after which the next item is taken; the input stalls while the eight
// beats are being loaded. The system setting register is written through cfg_we and cfg_data,
// resets to 1, and should only be written while idle.
module seven_segment_frame_buffer_ctrl_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  ssfb_pkg::ssfb_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output ssfb_pkg::ssfb_rsp_t rsp,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data
);
  import ssfb_pkg::*;

  ssfb_cmd_t    cmd;
  ssfb_status_t status;

  ssfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_mode  (req.mode),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ssfb_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ----- hw/rtl/ssfb_checker.sv -----
module ssfb_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_stall,
  input ssfb_pkg::ssfb_req_t req,
  input logic                rsp_valid,
  input logic                rsp_stall,
  input ssfb_pkg::ssfb_rsp_t rsp
);
  import ssfb_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("Stalled bus beat changed or dropped.");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_stall)
    else $error("Block not idle after reset.");

  a_refresh_blocks: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.mode == MODE_REFRESH |=> req_stall)
    else $error("Input not stalled after a refresh was accepted.");

  a_start_stop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.start_before != rsp.stop_after)
    else $error("Bus beat marks both or neither of start and stop.");

endmodule

bind seven_segment_frame_buffer_ctrl_unit ssfb_checker u_ssfb_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// ----- dv/tb_seven_segment_frame_buffer_ctrl_unit.sv -----
`timescale 1ns / 1ps

module tb_seven_segment_frame_buffer_ctrl_unit;
  import ssfb_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_LEN   = 16;
  localparam int unsigned RANDOM_ITEMS = 78;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam int RIGHT_BYTE = 0;
  localparam int LED_BYTE   = 1;
  localparam int LEFT_BYTE  = 2;

  localparam logic [7:0] DIGIT_SEGMENTS [16] = '{
    8'hE7, 8'h81, 8'h75, 8'hB5, 8'h93, 8'hB6, 8'hF6, 8'h85,
    8'hF7, 8'hB7, 8'h66, 8'hF1, 8'h56, 8'hD3, 8'h62, 8'hC7
  };

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  ssfb_req_t  req       = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  ssfb_rsp_t  rsp;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_data  = '0;

  logic [7:0] frame_model [3];
  logic [7:0] system_setting_model;
  ssfb_rsp_t  bus_beats_due [$];

  int unsigned beat_errors   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned rsp_stall_pct = 0;
  int unsigned hold_token    = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  seven_segment_frame_buffer_ctrl_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic bit digit_code_rejected(input logic [7:0] code);
    return (code != BLANK_CODE) && (code > 8'd15);
  endfunction

  function automatic logic [7:0] next_digit_byte(input logic [7:0] old, input logic [7:0] code);
    if (code == BLANK_CODE) begin
      return old & POINT_MASK;
    end
    return DIGIT_SEGMENTS[code[3:0]];
  endfunction

  function automatic void queue_beat(input logic [7:0] data, input logic start, input logic stop,
                                     input logic fin);
    ssfb_rsp_t beat;
    beat.bus_byte     = data;
    beat.start_before = start;
    beat.stop_after   = stop;
    beat.last         = fin;
    bus_beats_due.push_back(beat);
  endfunction

  function automatic void update_frame_model(input ssfb_req_t item);
    logic [7:0] leds;
    case (item.mode)
      MODE_DIGITS: begin
        if (digit_code_rejected(item.left_digit_code) ||
            digit_code_rejected(item.right_digit_code)) begin
          frame_model[RIGHT_BYTE] = '0;
          frame_model[LEFT_BYTE]  = '0;
        end else begin
          frame_model[RIGHT_BYTE] = next_digit_byte(frame_model[RIGHT_BYTE],
                                                    item.right_digit_code);
          frame_model[LEFT_BYTE]  = next_digit_byte(frame_model[LEFT_BYTE],
                                                    item.left_digit_code);
        end
      end
      MODE_POINTS: begin
        if (item.point_select > SEL_LIMIT) begin
          foreach (frame_model[i]) frame_model[i] = '0;
        end else begin
          frame_model[LEFT_BYTE][3]  = item.point_select[0];
          frame_model[RIGHT_BYTE][3] = item.point_select[1];
        end
      end
      MODE_LEDS: begin
        if (item.key_led_bits > LED_LIMIT) begin
          foreach (frame_model[i]) frame_model[i] = '0;
        end else begin
          leds    = '0;
          leds[2] = item.key_led_bits[0];
          leds[1] = item.key_led_bits[1];
          leds[7] = item.key_led_bits[2];
          leds[6] = item.key_led_bits[3];
          leds[5] = item.key_led_bits[4];
          frame_model[LED_BYTE] = leds;
        end
      end
      default: begin
        queue_beat(CMD_SYSTEM, 1'b1, 1'b0, 1'b0);
        queue_beat(system_setting_model, 1'b0, 1'b1, 1'b0);
        queue_beat(CMD_RIGHT, 1'b1, 1'b0, 1'b0);
        queue_beat(frame_model[RIGHT_BYTE], 1'b0, 1'b1, 1'b0);
        queue_beat(CMD_LEDS, 1'b1, 1'b0, 1'b0);
        queue_beat(frame_model[LED_BYTE], 1'b0, 1'b1, 1'b0);
        queue_beat(CMD_LEFT, 1'b1, 1'b0, 1'b0);
        queue_beat(frame_model[LEFT_BYTE], 1'b0, 1'b1, 1'b1);
      end
    endcase
  endfunction

  function automatic ssfb_req_t make_item(input logic [1:0] mode, input logic [7:0] left,
                                          input logic [7:0] right, input logic [7:0] sel,
                                          input logic [7:0] keys);
    ssfb_req_t item;
    item.mode             = mode;
    item.left_digit_code  = left;
    item.right_digit_code = right;
    item.point_select     = sel;
    item.key_led_bits     = keys;
    return item;
  endfunction

  function automatic logic [7:0] random_digit_code();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return 8'($urandom_range(15));
    if (pick < 85) return BLANK_CODE;
    return 8'($urandom_range(255));
  endfunction

  function automatic ssfb_req_t random_item();
    ssfb_req_t item;
    item.mode             = 2'($urandom_range(3));
    item.left_digit_code  = random_digit_code();
    item.right_digit_code = random_digit_code();
    item.point_select     = ($urandom_range(99) < 80) ? 8'($urandom_range(3))
                                                      : 8'($urandom_range(255));
    item.key_led_bits     = ($urandom_range(99) < 80) ? 8'($urandom_range(31))
                                                      : 8'($urandom_range(255));
    return item;
  endfunction

  task automatic send_item(input ssfb_req_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do begin
      @(posedge clk);
    end while (req_stall);
    update_frame_model(item);
  endtask

  task automatic drain_beats();
    req_valid <= 1'b0;
    while (bus_beats_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_LEN) @(posedge clk);
  endtask

  task automatic write_system_setting(input logic [7:0] value);
    drain_beats();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    system_setting_model = value;
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_item(make_item(MODE_REFRESH, 8'h00, 8'h00, 8'h00, 8'h00));
  endtask

  task automatic test_digits_and_points();
    send_item(make_item(MODE_DIGITS, 8'h00, 8'h0F, 8'hFF, 8'hFF));
    send_item(make_item(MODE_POINTS, 8'hFF, 8'hFF, 8'h03, 8'hFF));
    send_item(make_item(MODE_DIGITS, BLANK_CODE, 8'h08, 8'h00, 8'h00));
    send_item(make_item(MODE_REFRESH, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_item(make_item(MODE_DIGITS, 8'h10, 8'h03, 8'h00, 8'h00));
    send_item(make_item(MODE_REFRESH, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(MODE_DIGITS, 8'h05, 8'hFE, 8'h00, 8'h00));
    send_item(make_item(MODE_POINTS, 8'h00, 8'h00, 8'h01, 8'h00));
    send_item(make_item(MODE_POINTS, 8'h00, 8'h00, 8'h02, 8'h00));
    send_item(make_item(MODE_POINTS, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(MODE_REFRESH, 8'h00, 8'h00, 8'h00, 8'h00));
  endtask

  task automatic test_leds_and_clears();
    send_item(make_item(MODE_DIGITS, 8'h09, 8'h0A, 8'h00, 8'h00));
    send_item(make_item(MODE_LEDS, 8'h00, 8'h00, 8'h00, 8'h1F));
    send_item(make_item(MODE_REFRESH, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(MODE_POINTS, 8'h00, 8'h00, 8'h04, 8'h00));
    send_item(make_item(MODE_LEDS, 8'h00, 8'h00, 8'h00, 8'h15));
    send_item(make_item(MODE_REFRESH, 8'h00, 8'h00, 8'h00, 8'h00));
    send_item(make_item(MODE_LEDS, 8'h00, 8'h00, 8'h00, 8'h20));
    send_item(make_item(MODE_LEDS, 8'h00, 8'h00, 8'h00, 8'h0A));
    send_item(make_item(MODE_POINTS, 8'h00, 8'h00, 8'hFF, 8'h00));
    send_item(make_item(MODE_REFRESH, 8'h00, 8'h00, 8'h00, 8'h00));
  endtask

  task automatic test_setting_extremes();
    write_system_setting(8'h00);
    send_item(make_item(MODE_REFRESH, 8'h00, 8'h00, 8'h00, 8'h00));
    write_system_setting(8'hFF);
    send_item(make_item(MODE_REFRESH, 8'h00, 8'h00, 8'h00, 8'h00));
  endtask

  task automatic test_output_backpressure();
    drain_beats();
    hold_token++;
    for (int i = 0; i < 24; i++) begin
      send_item((i % 3 == 0) ? make_item(MODE_REFRESH, 8'h00, 8'h00, 8'h00, 8'h00)
                             : random_item());
    end
    drain_beats();
  endtask

  task automatic test_random_phase(input int unsigned send_pct, input int unsigned stall_pct);
    write_system_setting(8'($urandom_range(255)));
    send_idle_pct = send_pct;
    rsp_stall_pct = stall_pct;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_item(random_item());
    end
    drain_beats();
  endtask

  task automatic note_mismatch(input string what, input ssfb_rsp_t want, input ssfb_rsp_t got);
    beat_errors++;
    if (beat_errors <= MAX_REPORTS) begin
      $write("%0t %s: expected byte %02h start %b stop %b last %b, ",
             $realtime, what, want.bus_byte, want.start_before, want.stop_after, want.last);
      $display("got byte %02h start %b stop %b last %b",
               got.bus_byte, got.start_before, got.stop_after, got.last);
    end
  endtask

  always @(posedge clk) begin
    ssfb_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (bus_beats_due.size() == 0) begin
        note_mismatch("unexpected beat", '0, rsp);
      end else begin
        want = bus_beats_due.pop_front();
        if (rsp.bus_byte !== want.bus_byte || rsp.start_before !== want.start_before ||
            rsp.stop_after !== want.stop_after || rsp.last !== want.last) begin
          note_mismatch("beat mismatch", want, rsp);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Timeout after %0d cycles without a beat", quiet_cycles);
        $display("seven_segment_frame_buffer_ctrl_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    foreach (frame_model[i]) frame_model[i] = '0;
    system_setting_model = SYS_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_digits_and_points();
    test_leds_and_clears();
    test_setting_extremes();
    test_output_backpressure();
    test_random_phase(0, 0);
    test_random_phase(45, 0);
    test_random_phase(0, 45);
    test_random_phase(18, 18);
    write_system_setting(SYS_RESET);
    send_item(make_item(MODE_REFRESH, 8'h00, 8'h00, 8'h00, 8'h00));
    drain_beats();

    if (beat_errors == 0 && bus_beats_due.size() == 0) begin
      $display("seven_segment_frame_buffer_ctrl_unit verification clean");
    end else begin
      $display("seven_segment_frame_buffer_ctrl_unit verification failed");
    end
    $finish;
  end

endmodule
